@@ design/png_scanline_unfilter_unit_macros.svh @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter assertion macros
// Shorthand for the concurrent checks of the unfilter unit.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_UNIT_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_UNIT_MACROS_SVH

// Check that is switched off while reset is asserted.
`define PSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds across reset.
`define PSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/psu_pkg.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared widths, register indexes, filter codes and the pipeline word type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psu_pkg;

  localparam int DATA_W              = 8;
  localparam int ROW_BYTES_W         = 13;
  localparam int PIXEL_BYTES_W       = 4;
  localparam int CFG_DATA_W          = 13;
  localparam int CFG_ADDR_W          = 1;
  localparam int MAX_ROW_BYTES_DEF   = 4096;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_ROW_BYTES   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_BYTES = 1'd1;

  localparam logic [DATA_W-1:0] FILTER_MAX = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  typedef struct packed {
    logic              filt;
    filter_t           filter;
    logic              bad;
    logic              first;
    logic              near_left;
    logic              last;
    logic [DATA_W-1:0] data;
  } item_t;

endpackage

`default_nettype wire

@@ design/psu_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without a read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psu_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/psu_ctrl.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter sequencer
// Holds the registers, tracks row position and issues the prior-row read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psu_ctrl import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF,
  parameter int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
  parameter int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [DATA_W-1:0]     in_data,
  input  wire logic                  in_frame,
  input  wire logic                  take,
  output logic                       item_valid,
  output item_t                      item,
  output logic      [CW-1:0]         item_col,
  output logic      [PW-1:0]         win_idx,
  output logic                       rd_en,
  output logic      [CW-1:0]         rd_addr
);

  localparam int LW = (CW + 1 > ROW_BYTES_W) ? CW + 1 : ROW_BYTES_W;

  logic [ROW_BYTES_W-1:0]   row_bytes;
  logic [PIXEL_BYTES_W-1:0] pixel_bytes;
  logic [CW-1:0]            column;
  logic                     in_row;
  logic                     first_row;
  filter_t                  row_filter;
  logic                     row_bad;

  logic [LW-1:0]            eff_row;
  logic [PIXEL_BYTES_W-1:0] eff_pix;
  logic [LW-1:0]            col_plus;
  logic                     last;
  logic                     accept;
  logic                     start;
  logic                     bad_code;

  always_comb begin
    eff_row = LW'(row_bytes);
    if (eff_row == '0) begin
      eff_row = LW'(1);
    end else if (eff_row > LW'(MAX_ROW_BYTES)) begin
      eff_row = LW'(MAX_ROW_BYTES);
    end
    eff_pix = pixel_bytes;
    if (eff_pix == '0) begin
      eff_pix = PIXEL_BYTES_W'(1);
    end else if (eff_pix > PIXEL_BYTES_W'(MAX_PIXEL_BYTES)) begin
      eff_pix = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
    end
  end

  assign win_idx  = PW'(eff_pix - PIXEL_BYTES_W'(1));
  assign col_plus = LW'(column) + LW'(1);
  assign last     = col_plus >= eff_row;
  assign in_ready = !item_valid || take;
  assign accept   = in_valid && in_ready;
  assign start    = in_frame || !in_row;
  assign bad_code = in_data > FILTER_MAX;
  assign rd_en    = accept && !start;
  assign rd_addr  = column;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes   <= ROW_BYTES_W'(1);
      pixel_bytes <= PIXEL_BYTES_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROW_BYTES:   row_bytes   <= cfg_wdata[ROW_BYTES_W-1:0];
        REG_PIXEL_BYTES: pixel_bytes <= cfg_wdata[PIXEL_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      in_row     <= 1'b0;
      first_row  <= 1'b1;
      row_filter <= FILT_NONE;
      row_bad    <= 1'b0;
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
      if (start) begin
        column     <= '0;
        in_row     <= 1'b1;
        row_bad    <= bad_code;
        row_filter <= bad_code ? FILT_NONE : filter_t'(in_data[2:0]);
        if (in_frame) begin
          first_row <= 1'b1;
        end
      end else if (last) begin
        column    <= '0;
        in_row    <= 1'b0;
        first_row <= 1'b0;
      end else begin
        column <= CW'(col_plus);
      end
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.filt      <= start;
      item.filter    <= row_filter;
      item.bad       <= row_bad;
      item.first     <= first_row;
      item.near_left <= LW'(column) < LW'(eff_pix);
      item.last      <= last;
      item.data      <= in_data;
      item_col       <= column;
    end
  end

endmodule

`default_nettype wire

@@ design/psu_recon.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter reconstruction stage
// Predicts from left, above and upper-left bytes and holds the output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psu_recon import psu_pkg::*; #(
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF,
  parameter int CW = 12,
  parameter int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire item_t             item,
  input  wire logic [CW-1:0]     item_col,
  input  wire logic [PW-1:0]     win_idx,
  input  wire logic [DATA_W-1:0] above,
  output logic                   take,
  output logic                   wr_en,
  output logic      [CW-1:0]     wr_addr,
  output logic      [DATA_W-1:0] wr_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [DATA_W-1:0] out_data,
  output logic                   out_last,
  output logic                   out_bad
);

  logic [DATA_W-1:0] left_win   [MAX_PIXEL_BYTES];
  logic [DATA_W-1:0] upleft_win [MAX_PIXEL_BYTES];

  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] c;
  logic [DATA_W-1:0] pred;
  logic [DATA_W-1:0] recon;
  logic [DATA_W:0]   avg_sum;

  function automatic logic [DATA_W-1:0] paeth(input logic [DATA_W-1:0] pa_in,
                                              input logic [DATA_W-1:0] pb_in,
                                              input logic [DATA_W-1:0] pc_in);
    logic signed [DATA_W+1:0] da;
    logic signed [DATA_W+1:0] db;
    logic signed [DATA_W+1:0] dc;
    logic [DATA_W+1:0]        pa;
    logic [DATA_W+1:0]        pb;
    logic [DATA_W+1:0]        pc;
    da = $signed({2'b00, pb_in}) - $signed({2'b00, pc_in});
    db = $signed({2'b00, pa_in}) - $signed({2'b00, pc_in});
    dc = da + db;
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return pa_in;
    end else if (pb <= pc) begin
      return pb_in;
    end
    return pc_in;
  endfunction

  assign take = item_valid && (item.filt || !out_valid || out_ready);

  always_comb begin
    a       = item.near_left ? '0 : left_win[win_idx];
    b       = item.first ? '0 : above;
    c       = (item.first || item.near_left) ? '0 : upleft_win[win_idx];
    avg_sum = {1'b0, a} + {1'b0, b};
    unique case (item.filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[DATA_W:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = '0;
    endcase
    recon = item.data + pred;
  end

  assign wr_en   = take && !item.filt;
  assign wr_addr = item_col;
  assign wr_data = recon;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_win[i]   <= '0;
        upleft_win[i] <= '0;
      end
    end else if (take) begin
      if (item.filt) begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
          left_win[i]   <= '0;
          upleft_win[i] <= '0;
        end
      end else begin
        left_win[0]   <= recon;
        upleft_win[0] <= b;
        for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
          left_win[i]   <= left_win[i-1];
          upleft_win[i] <= upleft_win[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_data <= recon;
      out_last <= item.last;
      out_bad  <= item.bad;
    end
  end

endmodule

`default_nettype wire

@@ design/png_scanline_unfilter_unit.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter unit
// Rebuilds raw image bytes from a filtered PNG scanline stream.
// ----------------------------------------------------------------------------
// Channel    Dir  tdata              tuser          tlast
// s_axis     in   data_byte[7:0]     frame_start    -
// m_axis     out  recon_byte[7:0]    bad_filter     row_last
// cfg        in   index 0 row_bytes, index 1 pixel_bytes, write only
//
// One byte is accepted per cycle unless a stalled output holds off input. The
// previous row sits in a RAM read on acceptance; the byte is rebuilt from
// that word and the left windows while it waits in the item register, and
// is then written to the output register.
// Reset is synchronous; the row RAM is not cleared, rows must not outgrow
// the first row of an image. A stalled output holds one byte and one more
// waits in the read stage before input is held off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module png_scanline_unfilter_unit import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // data_byte
  input  wire logic [0:0]            s_axis_tuser,   // frame_start
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [7:0]            m_axis_tdata,   // recon_byte
  output logic                       m_axis_tlast,
  output logic      [0:0]            m_axis_tuser    // bad_filter
);

  localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic              take;
  logic              item_valid;
  item_t             item;
  logic [CW-1:0]     item_col;
  logic [PW-1:0]     win_idx;
  logic              rd_en;
  logic [CW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              wr_en;
  logic [CW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  psu_ctrl #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .CW              (CW),
    .PW              (PW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .in_frame   (s_axis_tuser[0]),
    .take       (take),
    .item_valid (item_valid),
    .item       (item),
    .item_col   (item_col),
    .win_idx    (win_idx),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  psu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ROW_BYTES)
  ) u_prior_row (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  psu_recon #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .CW              (CW),
    .PW              (PW)
  ) u_recon (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_col   (item_col),
    .win_idx    (win_idx),
    .above      (rd_data),
    .take       (take),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_bad    (m_axis_tuser[0])
  );

endmodule

`default_nettype wire

@@ design/psu_checker.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter port checker
// Concurrent checks on the ports of the unfilter unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "png_scanline_unfilter_unit_macros.svh"

module psu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  logic in_word;
  logic out_stall;

  assign in_word   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // An output word appears only after an input word was taken in.
  `PSU_ASSERT(a_out_from_in, $rose(m_axis_tvalid) |-> $past(in_word, 2), "word without input")

  // With the output side ready the unit never holds off input.
  `PSU_ASSERT(a_ready_flow, m_axis_tready |-> s_axis_tready, "input stalled while output is ready")

  // Reset empties the output register.
  `PSU_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output valid after reset")

  // A stalled output word stays put.
  `PSU_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")

endmodule

bind png_scanline_unfilter_unit psu_checker u_psu_checker (.*);

`default_nettype wire

@@ dv/psu_recon_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter reconstruction checker
// Watches the configuration port and both streams of the unfilter unit. It
// rebuilds every filtered byte from its own copy of the row store, the left
// windows and the registers, then compares each output word in order.
// ----------------------------------------------------------------------------
module psu_recon_checker import psu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // data_byte
  input  logic [0:0]            s_axis_tuser,   // frame_start
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [7:0]            m_axis_tdata,   // recon_byte
  input  logic                  m_axis_tlast,
  input  logic [0:0]            m_axis_tuser,   // bad_filter
  output int unsigned           errors,
  output int unsigned           pending
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DATA_W-1:0] recon;
    logic              row_last;
    logic              bad;
  } recon_word_t;

  recon_word_t       expected_words[$];
  logic [DATA_W-1:0] prior_row [MAX_ROW_BYTES_DEF];
  logic [DATA_W-1:0] left_win [MAX_PIXEL_BYTES_DEF];
  logic [DATA_W-1:0] upleft_win [MAX_PIXEL_BYTES_DEF];
  logic [ROW_BYTES_W-1:0]   row_bytes_reg;
  logic [PIXEL_BYTES_W-1:0] pixel_bytes_reg;
  int unsigned column;
  filter_t     row_filter;
  logic        row_bad;
  logic        first_row;
  logic        in_row;
  int unsigned mismatches = 0;
  int unsigned outstanding = 0;

  assign errors  = mismatches;
  assign pending = outstanding;

  function automatic logic [DATA_W-1:0] filter_prediction(filter_t kind,
      logic [DATA_W-1:0] a, logic [DATA_W-1:0] b, logic [DATA_W-1:0] c);
    int da, db, dc, pa, pb, pc;
    da = a;
    db = b;
    dc = c;
    pa = db - dc;
    pb = da - dc;
    pc = da + db - 2 * dc;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    case (kind)
      FILT_SUB:   return a;
      FILT_UP:    return b;
      FILT_AVG:   return DATA_W'((da + db) >> 1);
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) return a;
        else if (pb <= pc) return b;
        else return c;
      end
      default:    return '0;
    endcase
  endfunction

  // A filter type byte opens a row; types above Paeth fall back to None.
  task open_row(input logic [DATA_W-1:0] kind);
    for (int i = 0; i < MAX_PIXEL_BYTES_DEF; i++) begin
      left_win[i]   = '0;
      upleft_win[i] = '0;
    end
    column     = 0;
    row_bad    = kind > FILTER_MAX;
    row_filter = row_bad ? FILT_NONE : filter_t'(kind[2:0]);
    in_row     = 1'b1;
  endtask

  always @(posedge clk) begin : track
    recon_word_t       got, want;
    logic [DATA_W-1:0] x, a, b, c, r;
    int unsigned       rb, bpp, col;
    if (rst) begin
      row_bytes_reg   = 1;
      pixel_bytes_reg = 1;
      open_row(FILT_NONE);
      in_row    = 1'b0;
      first_row = 1'b1;
      expected_words.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{recon: m_axis_tdata, row_last: m_axis_tlast, bad: m_axis_tuser[0]};
        if (expected_words.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: unexpected word recon=%02h last=%b bad=%b",
                     $time, got.recon, got.row_last, got.bad);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (got.recon !== want.recon || got.row_last !== want.row_last ||
              got.bad !== want.bad) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: word mismatch, expected recon=%02h last=%b bad=%b, got recon=%02h last=%b bad=%b",
                       $time, want.recon, want.row_last, want.bad,
                       got.recon, got.row_last, got.bad);
            mismatches++;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_addr)
          REG_ROW_BYTES:   row_bytes_reg   = cfg_wdata[ROW_BYTES_W-1:0];
          REG_PIXEL_BYTES: pixel_bytes_reg = cfg_wdata[PIXEL_BYTES_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        x = s_axis_tdata;
        if (s_axis_tuser[0]) begin
          first_row = 1'b1;
          open_row(x);
        end else if (!in_row) begin
          open_row(x);
        end else begin
          rb  = (row_bytes_reg == 0) ? 1 :
                (row_bytes_reg > MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF : row_bytes_reg;
          bpp = (pixel_bytes_reg == 0) ? 1 :
                (pixel_bytes_reg > MAX_PIXEL_BYTES_DEF) ? MAX_PIXEL_BYTES_DEF : pixel_bytes_reg;
          col = (column >= MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF - 1 : column;
          a = (col >= bpp) ? left_win[bpp-1] : '0;
          b = first_row ? '0 : prior_row[col];
          c = (first_row || col < bpp) ? '0 : upleft_win[bpp-1];
          r = x + filter_prediction(row_filter, a, b, c);
          for (int i = MAX_PIXEL_BYTES_DEF - 1; i > 0; i--) begin
            left_win[i]   = left_win[i-1];
            upleft_win[i] = upleft_win[i-1];
          end
          left_win[0]    = r;
          upleft_win[0]  = b;
          prior_row[col] = r;
          expected_words.push_back('{recon: r, row_last: (col + 1 >= rb), bad: row_bad});
          if (col + 1 >= rb) begin
            in_row    = 1'b0;
            first_row = 1'b0;
            column    = 0;
          end else begin
            column = col + 1;
          end
        end
      end
    end
    outstanding = expected_words.size();
  end

endmodule

@@ dv/png_scanline_unfilter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter unit testbench
// Drives filtered scanline images through the unit under a range of row and
// pixel sizes, with random gaps on both streams and one long output stall.
// A directed opening covers each filter type, bad types and a frame start
// inside a row; random images with some abandoned rows follow.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_unit_tb;
  import psu_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned RANDOM_ITEMS  = 1000;
  localparam int unsigned LONG_ROW      = 200;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam logic [DATA_W-1:0] FILT_BAD_LOW  = FILTER_MAX + 8'd1;
  localparam logic [DATA_W-1:0] FILT_BAD_HIGH = 8'hFF;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;
  logic [0:0]            m_axis_tuser;

  int unsigned errors;
  int unsigned pending;
  int unsigned random_items = 0;
  int unsigned cycle_count = 0;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;
  bit          long_hold = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  png_scanline_unfilter_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  psu_recon_checker u_recon_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (errors),
    .pending       (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("png_scanline_unfilter_unit test failed");
      $finish;
    end
  end

  // Output side: a random hold-off before each word, and one long stall on request.
  initial begin : sink
    int unsigned gap;
    m_axis_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = sink_calm ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic frame_start);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= data;
    s_axis_tuser  <= frame_start;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
  endtask

  task automatic send_filter(input filter_t kind, input logic frame_start);
    send_byte({5'd0, kind}, frame_start);
  endtask

  // Drains the unit so that the registers can be rewritten safely.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input int unsigned row_len, input int unsigned pix);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_ROW_BYTES;
    cfg_wdata <= CFG_DATA_W'(row_len);
    @(posedge clk);
    cfg_addr  <= REG_PIXEL_BYTES;
    cfg_wdata <= CFG_DATA_W'(pix);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One image of equal rows; a row may be cut short, which leaves it to the
  // frame start of the next image.
  task automatic send_image(input int unsigned row_len, input int unsigned rows,
                            input bit may_cut);
    logic [7:0]  kind;
    logic [7:0]  data;
    int unsigned cut;
    for (int unsigned row = 0; row < rows; row++) begin
      kind = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, FILTER_MAX)) :
                                          8'($urandom_range(FILT_BAD_LOW, FILT_BAD_HIGH));
      cut = (may_cut && $urandom_range(0, 15) == 0) ? $urandom_range(0, row_len - 1) : row_len;
      send_byte(kind, row == 0);
      random_items++;
      for (int unsigned col = 0; col < cut; col++) begin
        case ($urandom_range(0, 9))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom);
        endcase
        send_byte(data, 1'b0);
        random_items++;
      end
      if (cut < row_len) return;
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned target;
    int unsigned rb_raw;
    int unsigned pb_raw;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_addr      <= REG_ROW_BYTES;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Single-byte rows at the reset sizes, starting without a frame start.
    send_filter(FILT_NONE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(FILT_BAD_HIGH, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(FILT_BAD_LOW, 1'b0);
    send_byte(8'h7F, 1'b0);

    settle();
    write_regs(3, 2);
    send_filter(FILT_SUB, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_filter(FILT_UP, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_filter(FILT_AVG, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_filter(FILT_PAETH, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_filter(FILT_SUB, 1'b0);
    send_byte(8'h55, 1'b0);
    send_filter(FILT_PAETH, 1'b1);
    send_byte(8'h01, 1'b0);

    // A long row with both registers above range, left open for the next
    // frame start.
    settle();
    write_regs(8191, 15);
    src_calm  = 1'b1;
    sink_calm = 1'b1;
    send_filter(FILT_PAETH, 1'b1);
    for (int unsigned i = 0; i < LONG_ROW; i++) begin
      send_byte(8'($urandom), 1'b0);
    end

    phase = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      phase++;
      case (phase)
        1: begin
          rb_raw = 1;
          pb_raw = MAX_PIXEL_BYTES_DEF;
        end
        2: begin
          rb_raw = 0;
          pb_raw = 0;
        end
        3: begin
          rb_raw = 9;
          pb_raw = MAX_PIXEL_BYTES_DEF;
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       rb_raw = 0;
            1:       rb_raw = $urandom_range(13, 64);
            default: rb_raw = $urandom_range(1, 12);
          endcase
          pb_raw = $urandom_range(0, 15) |
                   (($urandom_range(0, 3) == 0) ? ($urandom_range(1, 511) << 4) : 0);
        end
      endcase
      settle();
      write_regs(rb_raw, pb_raw);
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      if (phase == 4) long_hold = 1'b1;
      target = random_items + $urandom_range(60, 140);
      while (random_items < target)
        send_image((rb_raw == 0) ? 1 : rb_raw, $urandom_range(1, 4), 1'b1);
    end

    settle();
    if (errors == 0) begin
      $display("png_scanline_unfilter_unit test passed");
    end else begin
      $display("png_scanline_unfilter_unit test failed");
    end
    $finish;
  end

endmodule
